[hdl/tecrp_pkg.sv]
// Package for the terminal escape color reply parser.
// Holds the mode, sequencer and parse-phase types, the result beat type,
// character codes and the hex and scale helpers. No dependencies.
package tecrp_pkg;

   // Character codes
   localparam logic [7:0] CH_ESC       = 8'h1b;
   localparam logic [7:0] CH_BEL       = 8'h07;
   localparam logic [7:0] CH_RBRACKET  = 8'h5d;  // ']'
   localparam logic [7:0] CH_LBRACKET  = 8'h5b;  // '['
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_CSI_LO    = 8'h40;
   localparam logic [7:0] CH_CSI_HI    = 8'h7e;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_ONE       = 8'h31;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SEMI      = 8'h3b;
   localparam logic [7:0] CH_COLON     = 8'h3a;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_LC_A      = 8'h61;
   localparam logic [7:0] CH_LC_B      = 8'h62;
   localparam logic [7:0] CH_LC_F      = 8'h66;
   localparam logic [7:0] CH_LC_G      = 8'h67;
   localparam logic [7:0] CH_LC_R      = 8'h72;
   localparam logic [7:0] CH_UC_A      = 8'h41;
   localparam logic [7:0] CH_UC_F      = 8'h46;

   // Result kinds
   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_FG   = 2'd1;
   localparam logic [1:0] KIND_BG   = 2'd2;

   // Restoring divider length: numerator bits
   localparam int DIV_STEPS = 24;

   // Escape parser mode
   typedef enum logic [4:0] {
      MODE_GROUND  = 5'b00001,
      MODE_ESC     = 5'b00010,
      MODE_OSC     = 5'b00100,
      MODE_OSC_ESC = 5'b01000,
      MODE_CSI     = 5'b10000
   } mode_type;

   // Byte sequencer
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_READ   = 6'b000100,
      ST_EVAL   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_REPORT = 6'b100000
   } seq_state_type;

   // What the content walk expects next
   typedef enum logic [8:0] {
      PH_ONE     = 9'b000000001,
      PH_SEL     = 9'b000000010,
      PH_SEMI    = 9'b000000100,
      PH_R       = 9'b000001000,
      PH_G       = 9'b000010000,
      PH_B       = 9'b000100000,
      PH_COLON_A = 9'b001000000,
      PH_COLON   = 9'b010000000,
      PH_CHAN    = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } rsp_beat_type;

   // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      logic       ok;
      d  = 8'h00;
      ok = 1'b0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d  = c - CH_ZERO;
         ok = 1'b1;
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
         d  = c - CH_LC_A + 8'd10;
         ok = 1'b1;
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
         d  = c - CH_UC_A + 8'd10;
         ok = 1'b1;
      end
      return {ok, d[3:0]};
   endfunction

   // Full-scale value of a channel with the given digit count
   function automatic logic [15:0] scale_full(input logic [2:0] ndig);
      logic [15:0] f;
      unique case (ndig)
         3'd1:    f = 16'h000f;
         3'd2:    f = 16'h00ff;
         3'd3:    f = 16'h0fff;
         default: f = 16'hffff;
      endcase
      return f;
   endfunction

endpackage

[hdl/terminal_escape_color_reply_parser_top.sv]
// Top level of the terminal escape color reply parser.
// Escape mode tracking, OSC content memory, content walk sequencer with a
// shared restoring divider, and a two-beat result queue. Uses tecrp_pkg.
//
//   channel | dir | handshake           | payload
//   req     | in  | tvalid/tready       | tdata[7:0] in_byte
//   rsp     | out | tvalid/tready/tlast | tdata: out_byte, red, green, blue; tuser: kind
//   csr     | in  | we                  | wdata[15:0] passthrough_limit
//
// An ordinary byte is accepted, then decoded; the decode is held while earlier
// results still wait in the result queue. A BEL or ESC-backslash terminator
// walks the stored content through one memory read port, reading and then
// evaluating each character, and runs each color channel through the
// bit-serial divider. Reset sets only the control registers; the content
// memory is not cleared. req_tready is low while a byte is in work.
module terminal_escape_color_reply_parser_top
   import tecrp_pkg::*;
#(
   parameter int CONTENT_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [15:8] red, [23:16] green, [31:24] blue
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(CONTENT_DEPTH);

   // Control state
   seq_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   phase_type     phase_ff, phase_in;
   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [15:0]   limit_ff;
   logic [15:0]   passed_ff, passed_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          rd_ff, rd_in;

   // Payload state
   logic [7:0]    byte_ff, byte_in;
   logic          bg_ff, bg_in;
   logic [1:0]    chan_ff, chan_in;
   logic [2:0]    ndig_ff, ndig_in;
   logic [15:0]   val_ff, val_in;
   logic          slash_ff, slash_in;
   logic [15:0]   rem_ff, rem_in;
   logic [23:0]   num_ff, num_in;
   logic [7:0]    quo_ff, quo_in;
   logic [4:0]    step_ff, step_in;
   logic [7:0]    red_ff, red_in;
   logic [7:0]    green_ff, green_in;
   logic [7:0]    blue_ff, blue_in;
   rsp_beat_type  slot_ff [2];

   // Content memory
   logic [7:0]    mem [CONTENT_DEPTH];
   logic [7:0]    mem_rd_ff;
   logic          mem_we;

   // Combinational helpers
   logic [7:0]    ch;
   logic [4:0]    hx;
   logic          e1, e2;
   logic [1:0]    push_n;
   rsp_beat_type  push0, push1;
   logic [15:0]   full;
   logic [16:0]   rem_sh;
   logic          qbit;
   logic [7:0]    quo_next;
   logic          pop;

   assign req_tready = (state_ff == ST_IDLE);
   assign ch         = (pos_ff < len_ff) ? mem_rd_ff : 8'h00;
   assign hx         = hex_value(ch);
   assign full       = scale_full(ndig_ff);
   assign rem_sh     = {rem_ff, num_ff[23]};
   assign qbit       = (rem_sh >= {1'b0, full});
   assign quo_next   = {quo_ff[6:0], qbit};
   assign e1         = (passed_ff < limit_ff);
   assign e2         = e1 && ((passed_ff + 16'd1) < limit_ff);

   // Sequencer and parser next state
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      passed_in = passed_ff;
      byte_in   = byte_ff;
      bg_in     = bg_ff;
      chan_in   = chan_ff;
      ndig_in   = ndig_ff;
      val_in    = val_ff;
      slash_in  = slash_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      mem_we    = 1'b0;
      push_n    = 2'd0;
      push0     = '0;
      push1     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // wait for the result queue to drain
            if (cnt_ff == 2'd0) begin
               state_in = ST_IDLE;
               unique case (mode_ff)
                  MODE_ESC: begin
                     if (byte_ff == CH_RBRACKET) begin
                        mode_in = MODE_OSC;
                        len_in  = '0;
                     end else if (byte_ff == CH_LBRACKET) begin
                        mode_in = MODE_CSI;
                     end else begin
                        // pass ESC and the byte, each under the limit
                        mode_in        = MODE_GROUND;
                        push0.kind     = KIND_PASS;
                        push0.out_byte = CH_ESC;
                        push0.last     = !e2;
                        push1.kind     = KIND_PASS;
                        push1.out_byte = byte_ff;
                        push1.last     = 1'b1;
                        push_n         = {1'b0, e1} + {1'b0, e2};
                        passed_in      = passed_ff + {14'd0, push_n};
                     end
                  end
                  MODE_OSC: begin
                     if (byte_ff == CH_BEL) begin
                        mode_in  = MODE_GROUND;
                        state_in = ST_READ;
                        pos_in   = '0;
                        phase_in = PH_ONE;
                     end else if (byte_ff == CH_ESC) begin
                        mode_in = MODE_OSC_ESC;
                     end else if (len_ff < AW'(CONTENT_DEPTH - 1)) begin
                        mem_we = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  MODE_OSC_ESC: begin
                     if (byte_ff == CH_BACKSLASH) begin
                        mode_in  = MODE_GROUND;
                        state_in = ST_READ;
                        pos_in   = '0;
                        phase_in = PH_ONE;
                     end else begin
                        mode_in = MODE_OSC;
                     end
                  end
                  MODE_CSI: begin
                     if (byte_ff >= CH_CSI_LO && byte_ff <= CH_CSI_HI) begin
                        mode_in = MODE_GROUND;
                     end
                  end
                  default: begin
                     if (byte_ff == CH_ESC) begin
                        mode_in = MODE_ESC;
                     end else begin
                        push0.kind     = KIND_PASS;
                        push0.out_byte = byte_ff;
                        push0.last     = 1'b1;
                        push_n         = {1'b0, e1};
                        passed_in      = passed_ff + {15'd0, e1};
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // default: give up on a malformed reply
            state_in = ST_IDLE;
            len_in   = '0;
            unique case (phase_ff)
               PH_ONE: begin
                  if (ch == CH_ONE) begin
                     phase_in = PH_SEL;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_SEL: begin
                  if (ch == CH_ZERO || ch == CH_ONE) begin
                     bg_in    = (ch == CH_ONE);
                     phase_in = PH_SEMI;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_SEMI: begin
                  if (ch == CH_SEMI) begin
                     phase_in = PH_R;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_R: begin
                  if (ch == CH_LC_R) begin
                     phase_in = PH_G;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_G: begin
                  if (ch == CH_LC_G) begin
                     phase_in = PH_B;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_B: begin
                  if (ch == CH_LC_B) begin
                     phase_in = PH_COLON_A;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_COLON_A: begin
                  if (ch == CH_COLON) begin
                     phase_in = PH_CHAN;
                     chan_in  = 2'd0;
                     ndig_in  = 3'd0;
                     val_in   = 16'd0;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end else if (ch == CH_LC_A) begin
                     phase_in = PH_COLON;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               PH_COLON: begin
                  if (ch == CH_COLON) begin
                     phase_in = PH_CHAN;
                     chan_in  = 2'd0;
                     ndig_in  = 3'd0;
                     val_in   = 16'd0;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end
               end
               default: begin
                  if (ndig_ff != 3'd4 && hx[4]) begin
                     // accumulate one hex digit
                     val_in   = {val_ff[11:0], hx[3:0]};
                     ndig_in  = ndig_ff + 3'd1;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_READ;
                     len_in   = len_ff;
                  end else if (ndig_ff != 3'd0) begin
                     len_in = len_ff;
                     if (chan_ff == 2'd3) begin
                        state_in = ST_REPORT;
                     end else begin
                        // load the divider with v*255 + full/2
                        slash_in = (ch == CH_SLASH);
                        num_in   = {val_ff, 8'h00} - {8'h00, val_ff}
                                   + {8'h00, 1'b0, full[15:1]};
                        rem_in   = 16'd0;
                        quo_in   = 8'd0;
                        step_in  = 5'd0;
                        state_in = ST_DIV;
                     end
                  end
               end
            endcase
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (qbit) begin
               rem_in = 16'(rem_sh - {1'b0, full});
            end else begin
               rem_in = rem_sh[15:0];
            end
            num_in  = {num_ff[22:0], 1'b0};
            quo_in  = quo_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(DIV_STEPS - 1)) begin
               unique case (chan_ff)
                  2'd0:    red_in   = quo_next;
                  2'd1:    green_in = quo_next;
                  default: blue_in  = quo_next;
               endcase
               if (slash_ff) begin
                  chan_in  = chan_ff + 2'd1;
                  ndig_in  = 3'd0;
                  val_in   = 16'd0;
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_READ;
               end else if (chan_ff == 2'd2) begin
                  state_in = ST_REPORT;
               end else begin
                  state_in = ST_IDLE;
                  len_in   = '0;
               end
            end
         end
         default: begin
            // emit the color report
            push0.kind  = bg_ff ? KIND_BG : KIND_FG;
            push0.red   = red_ff;
            push0.green = green_ff;
            push0.blue  = blue_ff;
            push0.last  = 1'b1;
            push_n      = 2'd1;
            state_in    = ST_IDLE;
            len_in      = '0;
         end
      endcase
   end

   // Result queue: pushes land only while empty, pops advance the read slot
   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (push_n != 2'd0) begin
         cnt_in = push_n;
         rd_in  = 1'b0;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in  = !rd_ff;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {slot_ff[rd_ff].blue, slot_ff[rd_ff].green,
                        slot_ff[rd_ff].red, slot_ff[rd_ff].out_byte};
   assign rsp_tuser  = slot_ff[rd_ff].kind;
   assign rsp_tlast  = slot_ff[rd_ff].last;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= MODE_GROUND;
         phase_ff  <= PH_ONE;
         len_ff    <= '0;
         passed_ff <= 16'd0;
         limit_ff  <= 16'hffff;
         cnt_ff    <= 2'd0;
         rd_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         passed_ff <= passed_in;
         cnt_ff    <= cnt_in;
         rd_ff     <= rd_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      byte_ff  <= byte_in;
      bg_ff    <= bg_in;
      chan_ff  <= chan_in;
      ndig_ff  <= ndig_in;
      val_ff   <= val_in;
      slash_ff <= slash_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      if (push_n != 2'd0) begin
         slot_ff[0] <= push0;
         slot_ff[1] <= push1;
      end
   end

   // Content memory: write at the fill length, registered read at the walk position
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[len_ff] <= byte_ff;
      end
      mem_rd_ff <= mem[pos_ff];
   end

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue over two beats");

   a_push_empty: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (cnt_ff == 2'd0))
      else $error("push into a non-empty result queue");

   a_passed_mono: assert property (@(posedge clock) disable iff (reset)
      passed_ff >= $past(passed_ff))
      else $error("pass-through count went down");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (pos_ff <= len_ff))
      else $error("content walk ran past the stored length");

   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("undefined result kind");

endmodule
